[hdl/tgrw_pkg.sv]
// Shared types and constants for the text glyph raster writer.
// No dependencies; every other file in hdl/ except tgrw_ram references this package.
`default_nettype none

package tgrw_pkg;

    localparam int unsigned GLYPH_COLUMNS = 8;
    localparam int unsigned CURSOR_W      = 13;
    localparam int unsigned PIX_ADDR_W    = 24;
    localparam int unsigned CFG_W         = 13;
    localparam int unsigned CFG_IDX_W     = 1;

    localparam logic [CURSOR_W-1:0] CURSOR_MAX = 13'h1FFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd800;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd600;

    // word kinds and control characters
    localparam logic       KIND_CHAR    = 1'b0;
    localparam logic       KIND_FONT    = 1'b1;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] CODE_RETURN  = 8'd13;

    typedef struct packed {
        logic        kind;
        logic [7:0]  char_code;
        logic [11:0] font_row_index;
        logic [7:0]  font_row_data;
    } cmd_word_t;

    typedef struct packed {
        logic [PIX_ADDR_W-1:0] pixel_address;
        logic [7:0]            ink_bits;
        logic                  overflow;
        logic                  last;
    } pix_word_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic mul;
        logic base_load;
        logic emit_move;
        logic ovf_load;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic render;
        logic overflow;
        logic out_free;
        logic last_row;
    } dp_status_t;

endpackage

`default_nettype wire

[hdl/tgrw_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module tgrw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/tgrw_ctrl.sv]
// Sequencer for the glyph raster writer: idle, setup, base address, row emit.
// Depends on tgrw_pkg.
`default_nettype none

module tgrw_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    input  wire tgrw_pkg::dp_status_t status,
    output tgrw_pkg::ctrl_cmd_t      cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_BASE = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cmd_stall  = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = cmd_valid;
                if (cmd_valid && status.render)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (status.overflow)
                begin
                    if (status.out_free)
                    begin
                        cmd.ovf_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                cmd.base_load = 1'b1;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_move = 1'b1;
                    if (status.last_row)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hdl/tgrw_datapath.sv]
// Datapath: config registers, text cursor, glyph store, address math, output register.
// Depends on tgrw_pkg and tgrw_ram.
`default_nettype none

module tgrw_datapath #(
    parameter int unsigned GLYPH_ROWS    = 16,
    parameter int unsigned GLYPH_COUNT   = 256,
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [tgrw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tgrw_pkg::CFG_W-1:0]          cfg_data,
    input  wire tgrw_pkg::cmd_word_t                 cmd_word,
    input  wire logic                                pix_stall,
    output logic                                     pix_valid,
    output tgrw_pkg::pix_word_t                      pix_word,
    input  wire tgrw_pkg::ctrl_cmd_t                 cmd,
    output tgrw_pkg::dp_status_t                     status
);

    localparam int unsigned STORE_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
    localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);
    localparam int unsigned ROW_W       = $clog2(GLYPH_ROWS);
    localparam int unsigned SUM_W       = tgrw_pkg::CURSOR_W + 1;
    localparam int unsigned IDX_W       = 14;
    localparam int unsigned CODE_CMP_W  = 9;
    localparam int unsigned CW          = tgrw_pkg::CURSOR_W;
    localparam int unsigned AW          = tgrw_pkg::PIX_ADDR_W;

    localparam logic [SUM_W-1:0] DIM_MAX = SUM_W'(MAX_DIMENSION);
    localparam logic [SUM_W-1:0] GROWS   = SUM_W'(GLYPH_ROWS);
    localparam logic [SUM_W-1:0] GCOLS   = SUM_W'(tgrw_pkg::GLYPH_COLUMNS);
    localparam logic [SUM_W-1:0] CUR_LIM = {1'b0, tgrw_pkg::CURSOR_MAX};

    logic [tgrw_pkg::CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [tgrw_pkg::CFG_W-1:0] frame_height_reg, frame_height_next;
    logic [CW-1:0]              col_reg, col_next;
    logic [CW-1:0]              row_reg, row_next;
    logic [7:0]                 code_reg, code_next;
    logic [ROW_W-1:0]           glyph_row_reg, glyph_row_next;
    logic [AW-1:0]              prod_reg, prod_next;
    logic [AW-1:0]              addr_reg, addr_next;
    tgrw_pkg::pix_word_t        out_word_reg, out_word_next;
    logic                       out_valid_reg, out_valid_next;

    logic [SUM_W-1:0]   w_eff;
    logic [SUM_W-1:0]   h_eff;
    logic [SUM_W-1:0]   row_adv;
    logic [SUM_W-1:0]   col_adv;
    logic [CW-1:0]      row_step;
    logic [CW-1:0]      col_step;
    logic [2*SUM_W-1:0] prod_full;
    logic               wrap;
    logic               is_nl;
    logic               is_cr;
    logic               font_ok;
    logic               code_ok;
    logic               last_row;
    logic               out_free;
    logic [IDX_W-1:0]   font_idx;
    logic [IDX_W-1:0]   glyph_base;
    logic [IDX_W-1:0]   rd_next_idx;
    logic               ram_we;
    logic               ram_re;
    logic [STORE_AW-1:0] ram_raddr;
    logic [7:0]         ram_rdata;

    // effective frame size, clamped
    assign w_eff = ({1'b0, frame_width_reg} > DIM_MAX) ? DIM_MAX : {1'b0, frame_width_reg};
    assign h_eff = ({1'b0, frame_height_reg} > DIM_MAX) ? DIM_MAX : {1'b0, frame_height_reg};

    assign row_adv  = {1'b0, row_reg} + GROWS;
    assign col_adv  = {1'b0, col_reg} + GCOLS;
    assign row_step = (row_adv > CUR_LIM) ? tgrw_pkg::CURSOR_MAX : row_adv[CW-1:0];
    assign col_step = (col_adv > CUR_LIM) ? tgrw_pkg::CURSOR_MAX : col_adv[CW-1:0];
    assign wrap     = (col_adv > w_eff);

    assign is_nl = (cmd_word.char_code == tgrw_pkg::CODE_NEWLINE);
    assign is_cr = (cmd_word.char_code == tgrw_pkg::CODE_RETURN);

    assign font_idx = IDX_W'(cmd_word.font_row_index);
    assign font_ok  = (font_idx < IDX_W'(STORE_DEPTH));
    assign code_ok  = ({1'b0, code_reg} < CODE_CMP_W'(GLYPH_COUNT));
    assign last_row = (glyph_row_reg == ROW_W'(GLYPH_ROWS - 1));
    assign out_free = !out_valid_reg || !pix_stall;

    assign prod_full = {1'b0, row_reg} * w_eff;

    // glyph store addressing: code * rows + row
    assign glyph_base  = IDX_W'(code_reg) * IDX_W'(GLYPH_ROWS);
    assign rd_next_idx = glyph_base + IDX_W'(glyph_row_reg) + IDX_W'(1);

    assign ram_we    = cmd.accept && (cmd_word.kind == tgrw_pkg::KIND_FONT) && font_ok;
    assign ram_re    = code_ok && (cmd.base_load || (cmd.emit_move && !last_row));
    assign ram_raddr = cmd.base_load ? glyph_base[STORE_AW-1:0] : rd_next_idx[STORE_AW-1:0];

    tgrw_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (font_idx[STORE_AW-1:0]),
        .wdata (cmd_word.font_row_data),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.render   = (cmd_word.kind == tgrw_pkg::KIND_CHAR) && !is_nl && !is_cr;
    assign status.overflow = (row_adv > h_eff);
    assign status.out_free = out_free;
    assign status.last_row = last_row;

    assign pix_valid = out_valid_reg;
    assign pix_word  = out_word_reg;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tgrw_pkg::REG_FRAME_WIDTH:  frame_width_next  = cfg_data;
                tgrw_pkg::REG_FRAME_HEIGHT: frame_height_next = cfg_data;
            endcase
        end
    end

    // cursor moves on control codes, on wrap at accept, and after the last row
    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        code_next = code_reg;
        if (cmd.accept && (cmd_word.kind == tgrw_pkg::KIND_CHAR))
        begin
            if (is_nl)
            begin
                row_next = row_step;
                col_next = '0;
            end
            else if (is_cr)
            begin
                col_next = '0;
            end
            else
            begin
                code_next = cmd_word.char_code;
                if (wrap)
                begin
                    row_next = row_step;
                    col_next = '0;
                end
            end
        end
        if (cmd.emit_move && last_row)
        begin
            col_next = col_step;
        end
    end

    always_comb
    begin
        prod_next      = cmd.mul ? prod_full[AW-1:0] : prod_reg;
        addr_next      = addr_reg;
        glyph_row_next = glyph_row_reg;
        out_word_next  = out_word_reg;
        out_valid_next = out_valid_reg && pix_stall;
        if (cmd.base_load)
        begin
            addr_next      = prod_reg + AW'(col_reg);
            glyph_row_next = '0;
        end
        if (cmd.emit_move)
        begin
            out_word_next.pixel_address = addr_reg;
            out_word_next.ink_bits      = code_ok ? ram_rdata : 8'd0;
            out_word_next.overflow      = 1'b0;
            out_word_next.last          = last_row;
            out_valid_next              = 1'b1;
            addr_next                   = addr_reg + AW'(w_eff);
            glyph_row_next              = glyph_row_reg + ROW_W'(1);
        end
        if (cmd.ovf_load)
        begin
            out_word_next.pixel_address = '0;
            out_word_next.ink_bits      = '0;
            out_word_next.overflow      = 1'b1;
            out_word_next.last          = 1'b1;
            out_valid_next              = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= tgrw_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= tgrw_pkg::FRAME_HEIGHT_RST;
            col_reg          <= '0;
            row_reg          <= '0;
            glyph_row_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            glyph_row_reg    <= glyph_row_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        prod_reg     <= prod_next;
        addr_reg     <= addr_next;
        out_word_reg <= out_word_next;
    end

    // a dropped glyph reports a single, empty final word
    a_ovf_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.overflow |->
            out_word_reg.last && (out_word_reg.ink_bits == 8'd0)
            && (out_word_reg.pixel_address == '0))
        else $error("overflow word not empty");

    // a pending output word is never overwritten
    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_move || cmd.ovf_load) |-> out_free)
        else $error("output word overwritten while stalled");

    // new input is never taken while rows are being emitted
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_move |-> !cmd.accept && !cmd.base_load)
        else $error("accept during row emission");

endmodule

`default_nettype wire

[hdl/text_glyph_raster_writer.sv]
// Text glyph raster writer: word handling and rate (R = GLYPH_ROWS).
// Font-row, newline and return words: taken back to back, no output.
// Printable char: R row words; the row base goes to prod_reg, then the base
// address and first glyph store read, then one row per cycle into the output
// register unless pix_stall holds it. Dropped char (overflow): one flagged word.
// rst_n is asynchronous: cursor to 0,0, frame 800x600; glyph store content is not cleared.
`default_nettype none

module text_glyph_raster_writer #(
    parameter int unsigned GLYPH_ROWS    = 16,
    parameter int unsigned GLYPH_COUNT   = 256,
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [tgrw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tgrw_pkg::CFG_W-1:0]     cfg_data,
    // input words: characters and font rows
    input  wire logic                           cmd_valid,
    output logic                                cmd_stall,
    input  wire tgrw_pkg::cmd_word_t            cmd_word,
    // output words: one per glyph row, or one flagged overflow word
    output logic                                pix_valid,
    input  wire logic                           pix_stall,
    output tgrw_pkg::pix_word_t                 pix_word
);

    tgrw_pkg::ctrl_cmd_t  ctrl_cmd;
    tgrw_pkg::dp_status_t dp_status;

    // Controller: stalls input outside idle and steps the row emission.
    tgrw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .status    (dp_status),
        .cmd       (ctrl_cmd)
    );

    // Datapath: cursor, glyph store, one multiply for the row base address,
    // then a stride add per row. The output register decouples pix_stall.
    tgrw_datapath #(
        .GLYPH_ROWS    (GLYPH_ROWS),
        .GLYPH_COUNT   (GLYPH_COUNT),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_word  (cmd_word),
        .pix_stall (pix_stall),
        .pix_valid (pix_valid),
        .pix_word  (pix_word),
        .cmd       (ctrl_cmd),
        .status    (dp_status)
    );

endmodule

`default_nettype wire
